// ----- src/quadratic_sequence_cycle_finder_macros.svh -----
// Assertion macros used by the checker file.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef QUADRATIC_SEQUENCE_CYCLE_FINDER_MACROS_SVH
`define QUADRATIC_SEQUENCE_CYCLE_FINDER_MACROS_SVH

// Same-cycle implication
`define QSCF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define QSCF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/qscf_pkg.sv -----
// Shared types and constants for the quadratic sequence cycle finder.
// No dependencies; used by the top level and the checker.
`timescale 1ns / 1ps

package qscf_pkg;

	// Field widths
	localparam int IN_W        = 16;
	localparam int FI_W        = 16;
	localparam int RI_W        = 17;
	localparam int OUT_TDATA_W = 40;
	localparam int MOD_W       = 17;
	localparam int COEF_W      = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam int DEF_MAX_MODULUS = 65536;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODULUS  = 2'd0,
		REG_COEF_SQ  = 2'd1,
		REG_COEF_LIN = 2'd2,
		REG_COEF_CON = 2'd3
	} reg_idx_t;

	// Operand being reduced mod M at the start of a run
	typedef enum logic [1:0] {
		RED_SQ    = 2'd0,
		RED_LIN   = 2'd1,
		RED_CON   = 2'd2,
		RED_START = 2'd3
	} red_sel_t;

	// Run sequencer
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_RED_GO,
		ST_RED_WAIT,
		ST_LOOKUP,
		ST_CHECK,
		ST_MUL1_GO,
		ST_MUL1_WAIT,
		ST_MUL2_GO,
		ST_MUL2_WAIT,
		ST_DONE
	} state_t;

	// Configuration register set
	typedef struct packed {
		logic [MOD_W-1:0]  modulus;
		logic [COEF_W-1:0] coef_square;
		logic [COEF_W-1:0] coef_linear;
		logic [COEF_W-1:0] coef_constant;
	} cfg_t;

endpackage

// ----- src/quadratic_sequence_cycle_finder.sv -----
// Quadratic sequence cycle finder top level. Uses qscf_pkg, qscf_seen_mem, qscf_modmul.
// Run: clear sweep over M store entries (M the effective modulus), coefficients and
//   start value reduced mod M, then per step (R steps, R the repeat index) one store
//   read and two bit-serial modular multiplies of QW bits, QW = 16 by default.
// Throughput: one run at a time; the next request is taken once the result is registered.
// Reset: asynchronous, clears control and configuration; the store is swept at each run.
`timescale 1ns / 1ps

module quadratic_sequence_cycle_finder #(
	parameter int MAX_MODULUS = qscf_pkg::DEF_MAX_MODULUS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [qscf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qscf_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [qscf_pkg::IN_W-1:0]         s_axis_tdata,  // [15:0] start_value
	// result stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [qscf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // [15:0] first_index,
	                                                          // [32:16] repeat_index
);

	localparam int VW  = $clog2(MAX_MODULUS);
	localparam int MW  = $clog2(MAX_MODULUS + 1);
	localparam int SW  = MW;
	localparam int QW  = (VW > qscf_pkg::IN_W) ? VW : qscf_pkg::IN_W;
	localparam int CW  = (MW > qscf_pkg::MOD_W) ? MW : qscf_pkg::MOD_W;
	localparam int AW1 = VW + 1;
	localparam int PAD = qscf_pkg::OUT_TDATA_W - qscf_pkg::FI_W - qscf_pkg::RI_W;

	qscf_pkg::state_t   state_q, state_d;
	qscf_pkg::cfg_t     cfg_q;
	qscf_pkg::red_sel_t red_q;

	logic [MW-1:0] m_q;
	logic [VW-1:0] clr_q;
	logic [VW-1:0] a_q, b_q, c_q, x_q, acc_q;
	logic [qscf_pkg::IN_W-1:0] start_q;
	logic [SW-1:0] step_q;
	logic [SW-1:0] first_q;
	logic          out_valid_q;
	logic [qscf_pkg::FI_W-1:0] out_first_q;
	logic [qscf_pkg::RI_W-1:0] out_repeat_q;

	logic [CW-1:0] mod_ext;
	logic [CW-1:0] mod_max;
	logic [MW-1:0] m_eff;
	logic [VW-1:0] one_mod;
	logic [VW-1:0] clr_last;
	logic          out_free;

	logic          mem_we;
	logic [VW-1:0] mem_waddr;
	logic [SW-1:0] mem_wdata;
	logic [SW-1:0] mem_rdata;

	logic          mm_go;
	logic [VW-1:0] mm_p;
	logic [QW-1:0] mm_q;
	logic          mm_done;
	logic [VW-1:0] mm_r;

	logic [AW1-1:0] add_sum;
	logic [AW1-1:0] add_m;
	logic [VW-1:0]  add_in;
	logic [VW-1:0]  add_res;

	// effective modulus: zero reads as one, large values saturate
	always_comb begin
		mod_ext = CW'(cfg_q.modulus);
		mod_max = CW'(MAX_MODULUS);
		if (mod_ext == '0) begin
			m_eff = MW'(1);
		end else if (mod_ext > mod_max) begin
			m_eff = MW'(mod_max);
		end else begin
			m_eff = MW'(mod_ext);
		end
	end

	assign one_mod  = (m_q == MW'(1)) ? '0 : VW'(1);
	assign clr_last = VW'(m_q - 1'b1);
	assign out_free = !out_valid_q || m_axis_tready;

	// modular add of the multiplier result and b or c
	always_comb begin
		add_in  = (state_q == qscf_pkg::ST_MUL1_WAIT) ? b_q : c_q;
		add_m   = AW1'(m_q);
		add_sum = AW1'(mm_r) + AW1'(add_in);
		if (add_sum >= add_m) begin
			add_res = VW'(add_sum - add_m);
		end else begin
			add_res = VW'(add_sum);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qscf_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = qscf_pkg::ST_CLEAR;
				end
			end
			qscf_pkg::ST_CLEAR: begin
				if (clr_q == clr_last) begin
					state_d = qscf_pkg::ST_RED_GO;
				end
			end
			qscf_pkg::ST_RED_GO: state_d = qscf_pkg::ST_RED_WAIT;
			qscf_pkg::ST_RED_WAIT: begin
				if (mm_done) begin
					state_d = (red_q == qscf_pkg::RED_START) ? qscf_pkg::ST_LOOKUP
					                                         : qscf_pkg::ST_RED_GO;
				end
			end
			qscf_pkg::ST_LOOKUP: state_d = qscf_pkg::ST_CHECK;
			qscf_pkg::ST_CHECK: begin
				state_d = (mem_rdata != '0) ? qscf_pkg::ST_DONE : qscf_pkg::ST_MUL1_GO;
			end
			qscf_pkg::ST_MUL1_GO: state_d = qscf_pkg::ST_MUL1_WAIT;
			qscf_pkg::ST_MUL1_WAIT: begin
				if (mm_done) begin
					state_d = qscf_pkg::ST_MUL2_GO;
				end
			end
			qscf_pkg::ST_MUL2_GO: state_d = qscf_pkg::ST_MUL2_WAIT;
			qscf_pkg::ST_MUL2_WAIT: begin
				if (mm_done) begin
					state_d = qscf_pkg::ST_LOOKUP;
				end
			end
			qscf_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = qscf_pkg::ST_IDLE;
				end
			end
			default: state_d = qscf_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = x_q;
		mem_wdata     = SW'(step_q + 1'b1);
		mm_go         = 1'b0;
		mm_p          = a_q;
		mm_q          = QW'(x_q);
		unique case (state_q)
			qscf_pkg::ST_IDLE: s_axis_tready = 1'b1;
			qscf_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			qscf_pkg::ST_RED_GO: begin
				mm_go = 1'b1;
				mm_p  = one_mod;
				unique case (red_q)
					qscf_pkg::RED_SQ:    mm_q = QW'(cfg_q.coef_square);
					qscf_pkg::RED_LIN:   mm_q = QW'(cfg_q.coef_linear);
					qscf_pkg::RED_CON:   mm_q = QW'(cfg_q.coef_constant);
					qscf_pkg::RED_START: mm_q = QW'(start_q);
					default:             mm_q = '0;
				endcase
			end
			qscf_pkg::ST_CHECK: begin
				// first visit: record step+1; the entry is not read again this step
				mem_we = (mem_rdata == '0);
			end
			qscf_pkg::ST_MUL1_GO: begin
				mm_go = 1'b1;
				mm_p  = a_q;
			end
			qscf_pkg::ST_MUL2_GO: begin
				mm_go = 1'b1;
				mm_p  = acc_q;
			end
			default: ;
		endcase
	end

	// sequencer state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qscf_pkg::ST_IDLE;
			cfg_q   <= '{modulus: qscf_pkg::MOD_W'(1), default: '0};
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					qscf_pkg::REG_MODULUS:
						cfg_q.modulus <= qscf_pkg::MOD_W'(cfg_data);
					qscf_pkg::REG_COEF_SQ:
						cfg_q.coef_square <= qscf_pkg::COEF_W'(cfg_data);
					qscf_pkg::REG_COEF_LIN:
						cfg_q.coef_linear <= qscf_pkg::COEF_W'(cfg_data);
					qscf_pkg::REG_COEF_CON:
						cfg_q.coef_constant <= qscf_pkg::COEF_W'(cfg_data);
					default: ;
				endcase
			end
		end
	end

	// run datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			qscf_pkg::ST_IDLE: begin
				m_q     <= m_eff;
				start_q <= s_axis_tdata;
				clr_q   <= '0;
				red_q   <= qscf_pkg::RED_SQ;
			end
			qscf_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
			qscf_pkg::ST_RED_WAIT: begin
				if (mm_done) begin
					unique case (red_q)
						qscf_pkg::RED_SQ:    a_q <= mm_r;
						qscf_pkg::RED_LIN:   b_q <= mm_r;
						qscf_pkg::RED_CON:   c_q <= mm_r;
						qscf_pkg::RED_START: x_q <= mm_r;
						default: ;
					endcase
					red_q  <= qscf_pkg::red_sel_t'(red_q + 1'b1);
					step_q <= '0;
				end
			end
			qscf_pkg::ST_CHECK: first_q <= SW'(mem_rdata - 1'b1);
			qscf_pkg::ST_MUL1_WAIT: begin
				if (mm_done) begin
					acc_q <= add_res;
				end
			end
			qscf_pkg::ST_MUL2_WAIT: begin
				if (mm_done) begin
					x_q    <= add_res;
					step_q <= step_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// result register: holds a result while the next run is taken in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == qscf_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == qscf_pkg::ST_DONE && out_free) begin
			out_first_q  <= qscf_pkg::FI_W'(first_q);
			out_repeat_q <= qscf_pkg::RI_W'(step_q);
		end
	end

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {PAD'(0), out_repeat_q, out_first_q};

	qscf_seen_mem #(
		.DEPTH (MAX_MODULUS),
		.AW    (VW),
		.DW    (SW)
	) u_seen_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (x_q),
		.rdata (mem_rdata)
	);

	qscf_modmul #(
		.VW (VW),
		.MW (MW),
		.QW (QW)
	) u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mm_go),
		.p      (mm_p),
		.q      (mm_q),
		.m      (m_q),
		.done   (mm_done),
		.r      (mm_r)
	);

endmodule

// ----- src/qscf_seen_mem.sv -----
// First-seen step store: one write port, one read port, registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module qscf_seen_mem #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16,
	parameter int DW    = 17
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- src/qscf_modmul.sv -----
// Bit-serial modular multiplier: r = (p * q) mod m, one bit of q per cycle.
// Requires p < m. Depends on nothing.
`timescale 1ns / 1ps

module qscf_modmul #(
	parameter int VW = 16,
	parameter int MW = 17,
	parameter int QW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [VW-1:0] p,
	input  logic [QW-1:0] q,
	input  logic [MW-1:0] m,
	output logic          done,
	output logic [VW-1:0] r
);

	localparam int TW = VW + 2;
	localparam int CW = $clog2(QW);
	localparam logic [CW-1:0] LAST = CW'(QW - 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [QW-1:0] q_q;
	logic [VW-1:0] p_q;
	logic [VW-1:0] r_q;

	logic [TW-1:0] t;
	logic [TW-1:0] m1;
	logic [TW-1:0] m2;
	logic [TW-1:0] t_red;

	// r <- (2r + bit*p) mod m; the sum stays below 3m
	always_comb begin
		m1 = TW'(m);
		m2 = {m1[TW-2:0], 1'b0};
		t  = {1'b0, r_q, 1'b0} + (q_q[QW-1] ? TW'(p_q) : '0);
		if (t >= m2) begin
			t_red = t - m2;
		end else if (t >= m1) begin
			t_red = t - m1;
		end else begin
			t_red = t;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (go) begin
			p_q <= p;
			q_q <= q;
			r_q <= '0;
		end else if (busy_q) begin
			q_q <= {q_q[QW-2:0], 1'b0};
			r_q <= VW'(t_red);
		end
	end

	assign done = done_q;
	assign r    = r_q;

endmodule

// ----- src/qscf_checker.sv -----
// Port-level checks for the quadratic sequence cycle finder, bound to the top level.
// Depends on qscf_pkg and quadratic_sequence_cycle_finder_macros.svh.
`timescale 1ns / 1ps
`include "quadratic_sequence_cycle_finder_macros.svh"

module qscf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [qscf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	// a stalled result holds
	`QSCF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed under stall")

	// a taken request closes the input side for the run
	`QSCF_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after a request")

	// a new result only comes out of a running block
	`QSCF_ASSERT_SAME(a_result_from_run, $rose(m_axis_tvalid), $past(!s_axis_tready), "result appeared while idle")

	// a repeat never happens at step zero
	`QSCF_ASSERT_SAME(a_repeat_nonzero, m_axis_tvalid, m_axis_tdata[32:16] != 17'd0, "repeat index of zero")

endmodule

bind quadratic_sequence_cycle_finder qscf_checker u_qscf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
